FILE: src/fmeb_pkg.sv
// shared constants, types and index helpers for the fock element builder
`timescale 1ns / 1ps
package fmeb_pkg;

  localparam int MAX_BASIS      = 8;
  localparam int FRACTION_BITS  = 24;
  localparam int PAIR_COUNT     = MAX_BASIS * (MAX_BASIS + 1) / 2;
  localparam int INTEGRAL_DEPTH = PAIR_COUNT * (PAIR_COUNT + 1) / 2;
  localparam int MATRIX_DEPTH   = MAX_BASIS * MAX_BASIS;
  localparam int BASIS_RESET    = 8;

  localparam int IAW = $clog2(INTEGRAL_DEPTH);
  localparam int MAW = $clog2(MATRIX_DEPTH);
  localparam int KW  = (MAX_BASIS > 1) ? $clog2(MAX_BASIS) : 1;
  localparam int NW  = $clog2(MAX_BASIS + 1);

  // item field widths
  localparam int OP_W     = 2;
  localparam int ADDR_W   = 10;
  localparam int POS_W    = 3;
  localparam int VAL_W    = 32;
  localparam int BASIS_W  = 4;
  localparam int IN_DW    = 48;
  localparam int OUT_DW   = 40;

  // packed pair indices built from 3-bit fields reach 665
  localparam int PACK_W   = (IAW > 10) ? IAW : 10;

  // arithmetic widths
  localparam int DIFF_W   = VAL_W + 2;
  localparam int SPLIT_W  = 17;
  localparam int PLO_W    = VAL_W + SPLIT_W + 1;
  localparam int PHI_W    = VAL_W + DIFF_W - SPLIT_W;
  localparam int PROD_W   = VAL_W + DIFF_W;
  localparam int TERM_W   = PROD_W - FRACTION_BITS;
  localparam int ACC_W    = 64;
  localparam int ACC_LIMIT_LOG2 = 62;

  // configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic CFG_IDX_BASIS = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_WR_INTEGRAL = 2'd0,
    OP_WR_DENSITY  = 2'd1,
    OP_WR_CORE     = 2'd2,
    OP_COMPUTE     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_INIT = 3'd1,
    ST_RUN  = 3'd2,
    ST_WAIT = 3'd3,
    ST_DONE = 3'd4
  } state_t;

  typedef struct packed {
    logic          wr_en;
    logic          start;
    logic          init;
    logic          issue;
    logic          load_out;
    logic [KW-1:0] k;
    logic [KW-1:0] l;
  } dp_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_busy;
  } dp_stat_t;

  // symmetric packed index: max*(max+1)/2 + min
  function automatic logic [PACK_W-1:0] pair_index(input logic [PACK_W-1:0] a,
                                                    input logic [PACK_W-1:0] b);
    logic [PACK_W-1:0]   hi;
    logic [PACK_W-1:0]   lo;
    logic [2*PACK_W-1:0] prod;
    hi   = (a > b) ? a : b;
    lo   = (a > b) ? b : a;
    prod = (2*PACK_W)'(hi) * ((2*PACK_W)'(hi) + (2*PACK_W)'(1));
    return PACK_W'(prod >> 1) + lo;
  endfunction

endpackage

FILE: src/fmeb_datapath.sv
// stores, index pipeline, term arithmetic, accumulator and result register
`timescale 1ns / 1ps
module fmeb_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fmeb_pkg::dp_cmd_t                   cmd,
  input  logic [fmeb_pkg::OP_W-1:0]           in_op,
  input  logic [fmeb_pkg::ADDR_W-1:0]         in_addr,
  input  logic [fmeb_pkg::POS_W-1:0]          in_row,
  input  logic [fmeb_pkg::POS_W-1:0]          in_col,
  input  logic signed [fmeb_pkg::VAL_W-1:0]   in_value,
  input  logic                                out_tready,
  output fmeb_pkg::dp_stat_t                  stat,
  output logic                                out_tvalid,
  output logic [fmeb_pkg::POS_W-1:0]          out_row,
  output logic [fmeb_pkg::POS_W-1:0]          out_col,
  output logic signed [fmeb_pkg::VAL_W-1:0]   out_value,
  output logic                                out_sat
);

  localparam logic [fmeb_pkg::PROD_W-1:0] ROUND_HALF =
    fmeb_pkg::PROD_W'(1) << (fmeb_pkg::FRACTION_BITS - 1);
  localparam logic signed [fmeb_pkg::ACC_W:0] ACC_POS =
    (fmeb_pkg::ACC_W + 1)'(1) <<< fmeb_pkg::ACC_LIMIT_LOG2;
  localparam logic signed [fmeb_pkg::ACC_W:0] ACC_NEG = -ACC_POS;
  localparam logic signed [fmeb_pkg::ACC_W-1:0] VAL_MAX =
    {{(fmeb_pkg::ACC_W - fmeb_pkg::VAL_W + 1){1'b0}}, {(fmeb_pkg::VAL_W - 1){1'b1}}};
  localparam logic signed [fmeb_pkg::ACC_W-1:0] VAL_MIN = ~VAL_MAX;

  // stores
  logic signed [fmeb_pkg::VAL_W-1:0] int_mem  [fmeb_pkg::INTEGRAL_DEPTH];
  logic signed [fmeb_pkg::VAL_W-1:0] dens_mem [fmeb_pkg::MATRIX_DEPTH];
  logic signed [fmeb_pkg::VAL_W-1:0] core_mem [fmeb_pkg::MATRIX_DEPTH];

  logic [fmeb_pkg::MAW-1:0] in_mat_addr;
  logic                     in_addr_ok;
  logic                     in_pos_ok;

  // element context
  logic [fmeb_pkg::POS_W-1:0]        row_r;
  logic [fmeb_pkg::POS_W-1:0]        col_r;
  logic [fmeb_pkg::PACK_W-1:0]       ij_r;
  logic                              rc_ok_r;
  logic signed [fmeb_pkg::VAL_W-1:0] core_q_r;

  // pipeline
  logic                               v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic [fmeb_pkg::PACK_W-1:0]        pkl_r, prk_r, pcl_r;
  logic [fmeb_pkg::MAW-1:0]           dad1_r, dad2_r;
  logic [fmeb_pkg::PACK_W-1:0]        ia_r, ib_r;
  logic signed [fmeb_pkg::VAL_W-1:0]  a_q_r, b_q_r, d_q_r, d4_r;
  logic                               a_ok_r, b_ok_r;
  logic signed [fmeb_pkg::DIFF_W-1:0] diff_r;
  logic signed [fmeb_pkg::PLO_W-1:0]  p_lo_r;
  logic signed [fmeb_pkg::PHI_W-1:0]  p_hi_r;
  logic signed [fmeb_pkg::TERM_W-1:0] term_r;
  logic signed [fmeb_pkg::ACC_W-1:0]  acc_r;

  logic signed [fmeb_pkg::VAL_W-1:0]  a_val, b_val;
  logic signed [fmeb_pkg::DIFF_W-1:0] diff_nxt;
  logic signed [fmeb_pkg::PLO_W-1:0]  p_lo_nxt;
  logic signed [fmeb_pkg::PHI_W-1:0]  p_hi_nxt;
  logic [fmeb_pkg::PROD_W-1:0]        prod_sum;
  logic signed [fmeb_pkg::ACC_W:0]    acc_sum;
  logic signed [fmeb_pkg::ACC_W-1:0]  acc_nxt;

  // result register
  logic                              out_valid_r;
  logic [fmeb_pkg::POS_W-1:0]        out_row_r, out_col_r;
  logic signed [fmeb_pkg::VAL_W-1:0] out_value_r;
  logic                              out_sat_r;
  logic signed [fmeb_pkg::VAL_W-1:0] fock_nxt;
  logic                              sat_nxt;

  assign in_mat_addr = fmeb_pkg::MAW'(int'(in_row) * fmeb_pkg::MAX_BASIS + int'(in_col));
  assign in_addr_ok  = int'(in_addr) < fmeb_pkg::INTEGRAL_DEPTH;
  assign in_pos_ok   = (int'(in_row) < fmeb_pkg::MAX_BASIS) &&
                       (int'(in_col) < fmeb_pkg::MAX_BASIS);

  // store writes and reads
  always_ff @(posedge clk) begin
    if (cmd.wr_en && in_op == fmeb_pkg::OP_WR_INTEGRAL && in_addr_ok) begin
      int_mem[fmeb_pkg::IAW'(in_addr)] <= in_value;
    end
    a_q_r <= int_mem[ia_r[fmeb_pkg::IAW-1:0]];
    b_q_r <= int_mem[ib_r[fmeb_pkg::IAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en && in_op == fmeb_pkg::OP_WR_DENSITY && in_pos_ok) begin
      dens_mem[in_mat_addr] <= in_value;
    end
    d_q_r <= dens_mem[dad2_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en && in_op == fmeb_pkg::OP_WR_CORE && in_pos_ok) begin
      core_mem[in_mat_addr] <= in_value;
    end
    core_q_r <= core_mem[in_mat_addr];
  end

  // arithmetic between stages
  always_comb begin
    a_val    = a_ok_r ? a_q_r : '0;
    b_val    = b_ok_r ? b_q_r : '0;
    diff_nxt = (fmeb_pkg::DIFF_W'(a_val) <<< 1) - fmeb_pkg::DIFF_W'(b_val);
    // exact product in two halves of the difference
    p_lo_nxt = d4_r * $signed({1'b0, diff_r[fmeb_pkg::SPLIT_W-1:0]});
    p_hi_nxt = d4_r * $signed(diff_r[fmeb_pkg::DIFF_W-1:fmeb_pkg::SPLIT_W]);
    // rounding to nearest, ties upward
    prod_sum = (fmeb_pkg::PROD_W'(p_hi_r) << fmeb_pkg::SPLIT_W) +
               fmeb_pkg::PROD_W'(p_lo_r) + ROUND_HALF;
    acc_sum  = (fmeb_pkg::ACC_W + 1)'(acc_r) + (fmeb_pkg::ACC_W + 1)'(term_r);
    if (acc_sum > ACC_POS) begin
      acc_nxt = fmeb_pkg::ACC_W'(ACC_POS);
    end else if (acc_sum < ACC_NEG) begin
      acc_nxt = fmeb_pkg::ACC_W'(ACC_NEG);
    end else begin
      acc_nxt = fmeb_pkg::ACC_W'(acc_sum);
    end
    if (acc_r > VAL_MAX) begin
      fock_nxt = fmeb_pkg::VAL_W'(VAL_MAX);
      sat_nxt  = 1'b1;
    end else if (acc_r < VAL_MIN) begin
      fock_nxt = fmeb_pkg::VAL_W'(VAL_MIN);
      sat_nxt  = 1'b1;
    end else begin
      fock_nxt = acc_r[fmeb_pkg::VAL_W-1:0];
      sat_nxt  = 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      row_r   <= in_row;
      col_r   <= in_col;
      ij_r    <= fmeb_pkg::pair_index(fmeb_pkg::PACK_W'(in_row), fmeb_pkg::PACK_W'(in_col));
      rc_ok_r <= in_pos_ok;
    end
    pkl_r  <= fmeb_pkg::pair_index(fmeb_pkg::PACK_W'(cmd.k), fmeb_pkg::PACK_W'(cmd.l));
    prk_r  <= fmeb_pkg::pair_index(fmeb_pkg::PACK_W'(row_r), fmeb_pkg::PACK_W'(cmd.k));
    pcl_r  <= fmeb_pkg::pair_index(fmeb_pkg::PACK_W'(col_r), fmeb_pkg::PACK_W'(cmd.l));
    dad1_r <= fmeb_pkg::MAW'(int'(cmd.k) * fmeb_pkg::MAX_BASIS + int'(cmd.l));
    ia_r   <= fmeb_pkg::pair_index(ij_r, pkl_r);
    ib_r   <= fmeb_pkg::pair_index(prk_r, pcl_r);
    dad2_r <= dad1_r;
    a_ok_r <= int'(ia_r) < fmeb_pkg::INTEGRAL_DEPTH;
    b_ok_r <= int'(ib_r) < fmeb_pkg::INTEGRAL_DEPTH;
    diff_r <= diff_nxt;
    d4_r   <= d_q_r;
    p_lo_r <= p_lo_nxt;
    p_hi_r <= p_hi_nxt;
    term_r <= $signed(prod_sum[fmeb_pkg::PROD_W-1:fmeb_pkg::FRACTION_BITS]);
    if (cmd.init) begin
      acc_r <= rc_ok_r ? fmeb_pkg::ACC_W'(core_q_r) : '0;
    end else if (v6_r) begin
      acc_r <= acc_nxt;
    end
    if (cmd.load_out) begin
      out_row_r   <= row_r;
      out_col_r   <= col_r;
      out_value_r <= fock_nxt;
      out_sat_r   <= sat_nxt;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.pipe_busy = v1_r | v2_r | v3_r | v4_r | v5_r | v6_r;
  assign stat.out_busy  = out_valid_r & ~out_tready;

  assign out_tvalid = out_valid_r;
  assign out_row    = out_row_r;
  assign out_col    = out_col_r;
  assign out_value  = out_value_r;
  assign out_sat    = out_sat_r;

endmodule

FILE: src/fmeb_ctrl.sv
// sequencer: accepts items, walks the k,l loop and hands results over
`timescale 1ns / 1ps
module fmeb_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic [fmeb_pkg::OP_W-1:0]      in_op,
  input  logic [fmeb_pkg::BASIS_W-1:0]   basis_size,
  input  fmeb_pkg::dp_stat_t             stat,
  output logic                           in_tready,
  output fmeb_pkg::dp_cmd_t              cmd
);

  fmeb_pkg::state_t          state_r, state_nxt;
  logic [fmeb_pkg::KW-1:0]   k_r, k_nxt;
  logic [fmeb_pkg::KW-1:0]   l_r, l_nxt;
  logic [fmeb_pkg::NW-1:0]   n_r, n_nxt;
  logic [fmeb_pkg::NW-1:0]   n_cfg;
  logic                      k_last, l_last;

  always_comb begin
    if (int'(basis_size) > fmeb_pkg::MAX_BASIS) begin
      n_cfg = fmeb_pkg::NW'(fmeb_pkg::MAX_BASIS);
    end else begin
      n_cfg = fmeb_pkg::NW'(basis_size);
    end
  end

  assign k_last = fmeb_pkg::NW'(k_r) == n_r - fmeb_pkg::NW'(1);
  assign l_last = fmeb_pkg::NW'(l_r) == n_r - fmeb_pkg::NW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fmeb_pkg::ST_IDLE;
      k_r     <= '0;
      l_r     <= '0;
      n_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      l_r     <= l_nxt;
      n_r     <= n_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    l_nxt     = l_r;
    n_nxt     = n_r;
    in_tready = 1'b0;
    cmd       = '0;
    cmd.k     = k_r;
    cmd.l     = l_r;
    case (state_r)
      fmeb_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_op == fmeb_pkg::OP_COMPUTE) begin
            cmd.start = 1'b1;
            n_nxt     = n_cfg;
            state_nxt = fmeb_pkg::ST_INIT;
          end else begin
            cmd.wr_en = 1'b1;
          end
        end
      end
      fmeb_pkg::ST_INIT: begin
        cmd.init  = 1'b1;
        k_nxt     = '0;
        l_nxt     = '0;
        // empty basis: result is the core element alone
        state_nxt = (n_r == '0) ? fmeb_pkg::ST_WAIT : fmeb_pkg::ST_RUN;
      end
      fmeb_pkg::ST_RUN: begin
        cmd.issue = 1'b1;
        if (l_last) begin
          l_nxt = '0;
          if (k_last) begin
            state_nxt = fmeb_pkg::ST_WAIT;
          end else begin
            k_nxt = k_r + fmeb_pkg::KW'(1);
          end
        end else begin
          l_nxt = l_r + fmeb_pkg::KW'(1);
        end
      end
      fmeb_pkg::ST_WAIT: begin
        if (!stat.pipe_busy) begin
          state_nxt = fmeb_pkg::ST_DONE;
        end
      end
      fmeb_pkg::ST_DONE: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = fmeb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fmeb_pkg::ST_IDLE;
      end
    endcase
  end

  a_start_init: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> state_r == fmeb_pkg::ST_INIT)
    else $error("compute transfer not followed by accumulator init");

  a_loop_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == fmeb_pkg::ST_RUN |-> (fmeb_pkg::NW'(k_r) < n_r) && (fmeb_pkg::NW'(l_r) < n_r))
    else $error("k,l loop index beyond basis size");

  a_last_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fmeb_pkg::ST_RUN) && (state_nxt == fmeb_pkg::ST_WAIT) |=> stat.pipe_busy)
    else $error("last term not seen in the pipeline");

  a_load_clean: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !stat.pipe_busy && !stat.out_busy)
    else $error("result loaded with terms in flight or output occupied");

endmodule

FILE: src/fock_matrix_element_build.sv
// top level: stream ports, apb configuration register, controller and datapath
// write items are taken back to back; in_tready is high whenever the controller is idle
// a compute item walks n*n k,l terms (n = basis size, clamped to 8, none if 0) before out_tvalid,
// one k,l term per cycle through the dual-read integral memory and a six-stage term pipeline
// the next item is taken as soon as the result sits in the output register
// rst_n is synchronous; it clears control state and sets basis_size to 8, stores stay unset
`timescale 1ns / 1ps
module fock_matrix_element_build (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // integral_address[9:0], row[12:10], col[15:13], value[47:16]
  input  logic [fmeb_pkg::IN_DW-1:0]    in_tdata,
  // operation[1:0]
  input  logic [fmeb_pkg::OP_W-1:0]     in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // out_row[2:0], out_col[5:3], fock_value[37:6], zero pad[39:38]
  output logic [fmeb_pkg::OUT_DW-1:0]   out_tdata,
  // saturated[0]
  output logic                          out_tuser,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [fmeb_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [fmeb_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [fmeb_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);

  logic [fmeb_pkg::BASIS_W-1:0]      basis_size_r;
  fmeb_pkg::dp_cmd_t                 cmd;
  fmeb_pkg::dp_stat_t                stat;
  logic [fmeb_pkg::POS_W-1:0]        res_row, res_col;
  logic signed [fmeb_pkg::VAL_W-1:0] res_value;
  logic                              res_sat;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      basis_size_r <= fmeb_pkg::BASIS_W'(fmeb_pkg::BASIS_RESET);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == fmeb_pkg::CFG_IDX_BASIS) begin
      basis_size_r <= cfg_pwdata[fmeb_pkg::BASIS_W-1:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == fmeb_pkg::CFG_IDX_BASIS) ?
                      fmeb_pkg::CFG_DW'(basis_size_r) : '0;

  fmeb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_op      (in_tuser),
    .basis_size (basis_size_r),
    .stat       (stat),
    .in_tready  (in_tready),
    .cmd        (cmd)
  );

  fmeb_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_op      (in_tuser),
    .in_addr    (in_tdata[9:0]),
    .in_row     (in_tdata[12:10]),
    .in_col     (in_tdata[15:13]),
    .in_value   (in_tdata[47:16]),
    .out_tready (out_tready),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_row    (res_row),
    .out_col    (res_col),
    .out_value  (res_value),
    .out_sat    (res_sat)
  );

  assign out_tdata = {2'b00, res_value, res_col, res_row};
  assign out_tuser = res_sat;

endmodule

FILE: tb/sv/tb_fock_matrix_element_build.sv
// self-checking testbench for the fock matrix element builder
`timescale 1ns / 1ps
module tb_fock_matrix_element_build;
  import fmeb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam logic [CFG_AW-1:0] BASIS_ADDR = CFG_AW'(4 * CFG_IDX_BASIS);
  localparam int unsigned PHASES = 6;
  localparam int unsigned BASIS_PLAN [PHASES] = '{0, 3, 8, 15, 5, 2};
  localparam int unsigned ITEM_PLAN [PHASES] = '{60, 150, 330, 120, 160, 110};
  localparam longint ACC_CEIL = longint'(1) <<< 62;
  localparam logic signed [79:0] ROUND_HALF = 80'sd1 <<< (FRACTION_BITS - 1);

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] addr;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic [VAL_W-1:0]  value;
  } load_item_t;

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic [VAL_W-1:0] value;
    logic             sat;
  } fock_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [IN_DW-1:0]    in_tdata = '0;
  logic [OP_W-1:0]     in_tuser = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_DW-1:0]   out_tdata;
  logic                out_tuser;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]   cfg_paddr = '0;
  logic [CFG_DW-1:0]   cfg_pwdata = '0;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  fock_matrix_element_build dut (.*);

  // copy of the block's stores and register, updated on accepted transfers
  logic signed [VAL_W-1:0] integral_copy [INTEGRAL_DEPTH];
  logic signed [VAL_W-1:0] density_copy [MATRIX_DEPTH];
  logic signed [VAL_W-1:0] core_copy [MATRIX_DEPTH];
  logic [BASIS_W-1:0]      basis_copy = BASIS_W'(BASIS_RESET);

  // which entries the stimulus has written so far
  bit integral_known [INTEGRAL_DEPTH];
  bit density_known [MATRIX_DEPTH];
  bit core_known [MATRIX_DEPTH];

  load_item_t  item_backlog [$];
  fock_t       fock_due [$];
  load_item_t  in_item;
  int unsigned in_wait = 0;
  bit          in_calm = 1'b0;
  int unsigned out_wait = 0;
  bit          out_hold = 1'b0;
  bit          out_calm = 1'b0;
  int unsigned items_queued = 0;
  int unsigned fock_checked = 0;
  int unsigned fock_saturated = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  function automatic int unsigned tri_index(input int unsigned a, input int unsigned b);
    int unsigned hi;
    int unsigned lo;
    hi = (a > b) ? a : b;
    lo = (a > b) ? b : a;
    return hi * (hi + 1) / 2 + lo;
  endfunction

  function automatic fock_t fock_element(input logic [POS_W-1:0] r, input logic [POS_W-1:0] c);
    fock_t             res;
    int unsigned       n;
    int unsigned       ij;
    int unsigned       k;
    int unsigned       l;
    longint            acc;
    longint            a;
    longint            b;
    logic signed [79:0] dw;
    logic signed [79:0] fw;
    logic signed [79:0] prod;
    n   = (basis_copy > MAX_BASIS) ? MAX_BASIS : basis_copy;
    ij  = tri_index(r, c);
    acc = core_copy[r * MAX_BASIS + c];
    for (k = 0; k < n; k++) begin
      for (l = 0; l < n; l++) begin
        a    = integral_copy[tri_index(ij, tri_index(k, l))];
        b    = integral_copy[tri_index(tri_index(r, k), tri_index(c, l))];
        dw   = density_copy[k * MAX_BASIS + l];
        fw   = 2 * a - b;
        prod = dw * fw;
        // nearest, ties toward plus infinity
        acc  = acc + longint'((prod + ROUND_HALF) >>> FRACTION_BITS);
        if (acc > ACC_CEIL) acc = ACC_CEIL;
        if (acc < -ACC_CEIL) acc = -ACC_CEIL;
      end
    end
    res.row = r;
    res.col = c;
    res.sat = 1'b0;
    if (acc > 64'sd2147483647) begin
      acc     = 64'sd2147483647;
      res.sat = 1'b1;
    end else if (acc < -64'sd2147483648) begin
      acc     = -64'sd2147483648;
      res.sat = 1'b1;
    end
    res.value = 32'(acc);
    return res;
  endfunction

  task automatic absorb_transfer(input load_item_t t);
    case (t.op)
      OP_WR_INTEGRAL: begin
        if (t.addr < INTEGRAL_DEPTH) integral_copy[t.addr] = t.value;
      end
      OP_WR_DENSITY: density_copy[t.row * MAX_BASIS + t.col] = t.value;
      OP_WR_CORE:    core_copy[t.row * MAX_BASIS + t.col] = t.value;
      default:       fock_due.push_back(fock_element(t.row, t.col));
    endcase
  endtask

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // Q8.24 samples: mostly near unity, some wide, some at the range ends
  function automatic logic [VAL_W-1:0] fixed_sample();
    logic [VAL_W-1:0] v;
    v = $urandom();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return 32'h0000_0000;
          3:       return 32'h0000_0001;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1, 2:    return v;
      3, 4:    return {{4{v[27]}}, v[27:0]};
      default: return {{7{v[24]}}, v[24:0]};
    endcase
  endfunction

  task automatic queue_item(input op_t op, input logic [ADDR_W-1:0] addr,
                            input logic [POS_W-1:0] r, input logic [POS_W-1:0] c,
                            input logic [VAL_W-1:0] v);
    load_item_t t;
    t = '{op: op, addr: addr, row: r, col: c, value: v};
    item_backlog.push_back(t);
    case (op)
      OP_WR_INTEGRAL: if (addr < INTEGRAL_DEPTH) integral_known[addr] = 1'b1;
      OP_WR_DENSITY:  density_known[r * MAX_BASIS + c] = 1'b1;
      OP_WR_CORE:     core_known[r * MAX_BASIS + c] = 1'b1;
      default: ;
    endcase
    items_queued++;
  endtask

  task automatic fill_integral(input int unsigned at);
    if (!integral_known[at])
      queue_item(OP_WR_INTEGRAL, ADDR_W'(at), POS_W'($urandom_range(0, 7)),
                 POS_W'($urandom_range(0, 7)), fixed_sample());
  endtask

  // a compute preceded by writes of any entry it reads that is still unset
  task automatic queue_fock(input logic [POS_W-1:0] r, input logic [POS_W-1:0] c);
    int unsigned n;
    int unsigned ij;
    int unsigned k;
    int unsigned l;
    n  = (basis_copy > MAX_BASIS) ? MAX_BASIS : basis_copy;
    ij = tri_index(r, c);
    if (!core_known[r * MAX_BASIS + c])
      queue_item(OP_WR_CORE, ADDR_W'($urandom()), r, c, fixed_sample());
    for (k = 0; k < n; k++) begin
      for (l = 0; l < n; l++) begin
        if (!density_known[k * MAX_BASIS + l])
          queue_item(OP_WR_DENSITY, ADDR_W'($urandom()), POS_W'(k), POS_W'(l), fixed_sample());
        fill_integral(tri_index(ij, tri_index(k, l)));
        fill_integral(tri_index(tri_index(r, k), tri_index(c, l)));
      end
    end
    queue_item(OP_COMPUTE, ADDR_W'($urandom()), r, c, $urandom());
  endtask

  task automatic apb_cycle(input bit wr, input logic [CFG_AW-1:0] addr,
                           input logic [CFG_DW-1:0] wdata, output logic [CFG_DW-1:0] rdata);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic check_basis(input logic [BASIS_W-1:0] want);
    logic [CFG_DW-1:0] got;
    apb_cycle(1'b0, BASIS_ADDR, '0, got);
    if (got !== CFG_DW'(want))
      note_mismatch($sformatf("basis_size read exp %0d got %0h", want, got));
  endtask

  task automatic set_basis(input logic [BASIS_W-1:0] n);
    logic [CFG_DW-1:0] unused;
    // upper bits of pwdata are random and must not reach the register
    apb_cycle(1'b1, BASIS_ADDR, {(CFG_DW - BASIS_W)'($urandom()), n}, unused);
    basis_copy = n;
    check_basis(n);
  endtask

  task automatic settle();
    do @(negedge clk); while (item_backlog.size() != 0 || in_tvalid || fock_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_wait = 0;
    end else begin
      if (in_tvalid && in_tready) absorb_transfer(in_item);
      if (!in_tvalid || in_tready) begin
        if (in_wait != 0) begin
          in_wait--;
          in_tvalid <= 1'b0;
        end else if (item_backlog.size() != 0) begin
          in_item = item_backlog.pop_front();
          in_tdata  <= {in_item.value, in_item.col, in_item.row, in_item.addr};
          in_tuser  <= in_item.op;
          in_tvalid <= 1'b1;
          if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
          in_wait = in_calm ? 0 : $urandom_range(0, 13);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor; a stall either runs at once or only while a result waits
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_wait = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (fock_due.size() == 0) begin
          note_mismatch($sformatf("result with nothing expected: tdata %h tuser %b",
                                  out_tdata, out_tuser));
        end else begin
          fock_t want;
          want = fock_due.pop_front();
          fock_checked++;
          if (want.sat) fock_saturated++;
          if (out_tdata[2:0] !== want.row)
            note_mismatch($sformatf("out_row exp %0d got %0d", want.row, out_tdata[2:0]));
          if (out_tdata[5:3] !== want.col)
            note_mismatch($sformatf("out_col exp %0d got %0d", want.col, out_tdata[5:3]));
          if (out_tdata[37:6] !== want.value)
            note_mismatch($sformatf("fock_value (%0d,%0d) exp %h got %h",
                                    want.row, want.col, want.value, out_tdata[37:6]));
          if (out_tuser !== want.sat)
            note_mismatch($sformatf("saturated (%0d,%0d) exp %b got %b",
                                    want.row, want.col, want.sat, out_tuser));
        end
        if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
        out_wait = out_calm ? 0 : $urandom_range(0, 13);
        out_hold = $urandom_range(0, 1);
      end
      if (out_wait != 0) begin
        out_tready <= 1'b0;
        if (!out_hold || out_tvalid) out_wait--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, fock_due.size());
      $display("tb_fock_matrix_element_build failed");
      $finish;
    end
  end

  initial begin
    int unsigned p;
    int unsigned goal;
    int unsigned pick;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    check_basis(BASIS_W'(BASIS_RESET));

    // directed: rounding ties, range ends, both saturation sides, ignored writes
    set_basis(4'd1);
    queue_item(OP_WR_INTEGRAL, 10'd0, 3'd0, 3'd0, 32'h0080_0000);
    queue_item(OP_WR_DENSITY, 10'd0, 3'd0, 3'd0, 32'h0000_0001);
    queue_item(OP_WR_CORE, 10'd0, 3'd0, 3'd0, 32'h0000_0000);
    queue_fock(3'd0, 3'd0);
    queue_item(OP_WR_INTEGRAL, 10'd0, 3'd7, 3'd7, 32'hFF80_0000);
    queue_fock(3'd0, 3'd0);
    queue_item(OP_WR_DENSITY, 10'd0, 3'd0, 3'd0, 32'h7FFF_FFFF);
    queue_item(OP_WR_CORE, 10'd0, 3'd7, 3'd7, 32'h7FFF_FFFF);
    queue_item(OP_WR_INTEGRAL, 10'd630, 3'd0, 3'd0, 32'h7FFF_FFFF);
    queue_item(OP_WR_INTEGRAL, 10'd434, 3'd0, 3'd0, 32'h8000_0000);
    queue_fock(3'd7, 3'd7);
    queue_item(OP_WR_CORE, 10'd0, 3'd7, 3'd0, 32'h8000_0000);
    queue_item(OP_WR_INTEGRAL, 10'd406, 3'd0, 3'd0, 32'h8000_0000);
    queue_fock(3'd7, 3'd0);
    // one times the most negative difference lands just inside the range
    queue_item(OP_WR_DENSITY, 10'd0, 3'd0, 3'd0, 32'h0100_0000);
    queue_item(OP_WR_CORE, 10'd0, 3'd0, 3'd7, 32'h0000_0001);
    queue_fock(3'd0, 3'd7);
    queue_item(OP_WR_INTEGRAL, 10'(INTEGRAL_DEPTH), 3'd5, 3'd2, 32'hDEAD_BEEF);
    queue_item(OP_WR_INTEGRAL, 10'd1023, 3'd2, 3'd5, 32'h1234_5678);
    queue_item(OP_WR_INTEGRAL, 10'(INTEGRAL_DEPTH - 1), 3'd1, 3'd6, 32'h5A5A_5A5A);
    settle();

    for (p = 0; p < PHASES; p++) begin
      set_basis(BASIS_W'(BASIS_PLAN[p]));
      goal = items_queued + ITEM_PLAN[p];
      while (items_queued < goal) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          queue_fock(POS_W'($urandom_range(0, 7)), POS_W'($urandom_range(0, 7)));
        end else if (pick < 90) begin
          queue_item(op_t'($urandom_range(0, 2)), ADDR_W'($urandom_range(0, INTEGRAL_DEPTH - 1)),
                     POS_W'($urandom_range(0, 7)), POS_W'($urandom_range(0, 7)),
                     fixed_sample());
        end else begin
          // out-of-range integral address, dropped by the block
          queue_item(OP_WR_INTEGRAL, ADDR_W'($urandom_range(INTEGRAL_DEPTH, 1023)),
                     POS_W'($urandom_range(0, 7)), POS_W'($urandom_range(0, 7)), $urandom());
        end
      end
      settle();
    end

    $display("%0d load and compute items sent, %0d fock elements checked, %0d saturated",
             items_queued, fock_checked, fock_saturated);
    $display("basis sizes 1, 0, 3, 8, 15 and 5, 2 exercised; %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("tb_fock_matrix_element_build passed");
    end else begin
      $display("tb_fock_matrix_element_build failed");
    end
    $finish;
  end

endmodule
